>>> rtl/core/frsc_pkg.sv
package frsc_pkg;

   localparam int unsigned DefaultStackDepth = 256;
   localparam int unsigned CodeWordsReset    = 1024;
   localparam int unsigned StackCapReset     = 256;
   localparam int unsigned CsrWidth          = 21;
   localparam logic [31:0] CharMaxCode       = 32'd255;

   typedef enum logic [4:0] {
      OP_NOP   = 5'd0,
      OP_HALT  = 5'd1,
      OP_ADD   = 5'd2,
      OP_SUB   = 5'd3,
      OP_MUL   = 5'd4,
      OP_DIV   = 5'd5,
      OP_INC   = 5'd6,
      OP_DEC   = 5'd7,
      OP_LOOP  = 5'd8,
      OP_MOVR  = 5'd9,
      OP_LOAD  = 5'd10,
      OP_STORE = 5'd11,
      OP_IN    = 5'd12,
      OP_GET   = 5'd13,
      OP_OUT   = 5'd14,
      OP_PUT   = 5'd15,
      OP_SWAP  = 5'd16,
      OP_PUSH  = 5'd17,
      OP_POP   = 5'd18
   } op_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_HALT        = 3'd1,
      ST_BAD_INSTR   = 3'd2,
      ST_BAD_OPERAND = 3'd3,
      ST_BAD_ADDR    = 3'd4,
      ST_DIV_ZERO    = 3'd5,
      ST_STACK       = 3'd6,
      ST_IO          = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      COND_VALUE     = 2'd0,
      COND_EOF       = 2'd1,
      COND_MALFORMED = 2'd2,
      COND_OTHER     = 2'd3
   } cond_type;

   typedef enum logic [1:0] {
      PRINT_NONE   = 2'd0,
      PRINT_NUMBER = 2'd1,
      PRINT_CHAR   = 2'd2,
      PRINT_UNUSED = 2'd3
   } print_type;

   localparam logic CSR_CODE_WORDS     = 1'b0;
   localparam logic CSR_STACK_CAPACITY = 1'b1;

   typedef struct packed {
      logic signed [31:0] opcode;
      logic signed [31:0] operand_one;
      logic signed [31:0] operand_two;
      logic signed [31:0] console_value;
      logic        [1:0]  console_condition;
   } req_type;

   typedef struct packed {
      logic        [2:0]  status;
      logic signed [31:0] next_address;
      logic        [1:0]  print_kind;
      logic signed [31:0] print_value;
      logic        [8:0]  stack_count;
      logic signed [31:0] reg_a_value;
      logic signed [31:0] reg_b_value;
      logic signed [31:0] reg_c_value;
      logic signed [31:0] reg_d_value;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic div_step;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_div;
   } dp_sts_type;

endpackage

>>> rtl/core/frsc_datapath.sv
module frsc_datapath #(
   parameter int unsigned STACK_DEPTH = frsc_pkg::DefaultStackDepth
) (
   input  logic                             clock,
   input  logic                             reset,
   input  frsc_pkg::req_type                req_data,
   input  frsc_pkg::ctl_cmd_type            cmd,
   output frsc_pkg::dp_sts_type             sts,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [frsc_pkg::CsrWidth-1:0]    csr_wdata,
   output frsc_pkg::rsp_type                rsp_data
);
   import frsc_pkg::*;

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   logic [20:0] code_words_ff;
   logic [8:0]  stack_cap_ff;

   req_type     item_ff;
   logic [31:0] regs_ff [4];
   logic [31:0] pp_ff;
   status_type  status_ff;
   logic [8:0]  depth_ff;

   logic [31:0] stack_mem [STACK_DEPTH];
   logic [31:0] mem_rd_ff;
   logic [31:0] product_ff;
   logic [31:0] rem_ff;
   logic [31:0] quot_ff;
   logic [31:0] divisor_ff;
   logic        neg_ff;

   rsp_type     rsp_ff;

   // decode, all combinational from the captured transaction
   op_type      op;
   logic        op_ok;
   logic [1:0]  rsel;
   logic [1:0]  r2sel;
   logic        bad1;
   logic        bad2;
   logic [31:0] rv;
   logic signed [33:0] k;
   logic        slot_ok;
   logic [8:0]  slot_idx;
   logic [31:0] limit;
   logic        push_full;
   logic [AW-1:0] rd_addr;
   logic [31:0] mag_a;
   logic [31:0] mag_b;
   logic [32:0] rem_shift;
   logic        rem_ge;

   assign op_ok = (item_ff.opcode[31:5] == 27'd0) && (item_ff.opcode[4:0] <= OP_POP);
   assign op    = op_type'(item_ff.opcode[4:0]);
   assign bad1  = item_ff.operand_one[31:2] != 30'd0;
   assign bad2  = item_ff.operand_two[31:2] != 30'd0;
   assign rsel  = bad1 ? 2'd0 : item_ff.operand_one[1:0];
   assign r2sel = bad2 ? 2'd0 : item_ff.operand_two[1:0];
   assign rv    = regs_ff[rsel];

   assign k = 34'(signed'(regs_ff[3])) + 34'(signed'(item_ff.operand_two));
   assign slot_ok = (depth_ff != 9'd0) && !k[33] && (k < signed'({25'd0, depth_ff}));
   assign slot_idx = depth_ff - 9'd1 - k[8:0];
   assign limit = ({23'd0, stack_cap_ff} < 32'(STACK_DEPTH)) ? {23'd0, stack_cap_ff}
                                                            : 32'(STACK_DEPTH);
   assign push_full = {23'd0, depth_ff} >= limit;
   assign rd_addr = (op == OP_POP) ? AW'(depth_ff - 9'd1) : AW'(slot_idx);

   assign mag_a = regs_ff[0][31] ? (32'd0 - regs_ff[0]) : regs_ff[0];
   assign mag_b = rv[31] ? (32'd0 - rv) : rv;
   assign rem_shift = {rem_ff, quot_ff[31]};
   assign rem_ge = rem_shift >= {1'b0, divisor_ff};

   assign sts.need_div = op_ok && (op == OP_DIV) && (rv != 32'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         code_words_ff <= 21'(CodeWordsReset);
         stack_cap_ff  <= 9'(StackCapReset);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CODE_WORDS:     code_words_ff <= csr_wdata;
            CSR_STACK_CAPACITY: stack_cap_ff  <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // commit computation
   logic [31:0] regs_n [4];
   logic [31:0] pp_n;
   status_type  status_n;
   logic [8:0]  depth_n;
   print_type   pkind_n;
   logic [31:0] pval_n;
   logic        mem_we;
   logic [AW-1:0] mem_wa;
   logic        picks;
   logic [31:0] tmp;

   always_comb begin
      regs_n   = regs_ff;
      pp_n     = pp_ff;
      status_n = status_ff;
      depth_n  = depth_ff;
      pkind_n  = PRINT_NONE;
      pval_n   = 32'd0;
      mem_we   = 1'b0;
      mem_wa   = AW'(slot_idx);
      picks    = 1'b0;
      tmp      = 32'd0;
      if (status_ff == ST_OK) begin
         if (pp_ff[31] || (pp_ff >= {11'd0, code_words_ff})) begin
            status_n = ST_BAD_ADDR;
         end else if (!op_ok) begin
            status_n = ST_BAD_INSTR;
         end else begin
            picks = (op != OP_NOP) && (op != OP_HALT) && (op != OP_LOOP);
            if (picks && (bad1 || ((op == OP_SWAP) && bad2))) status_n = ST_BAD_OPERAND;
            unique case (op)
               OP_NOP:  pp_n = pp_ff + 32'd1;
               OP_HALT: status_n = ST_HALT;
               OP_ADD: begin
                  regs_n[0] = regs_ff[0] + rv;
                  pp_n = pp_ff + 32'd2;
               end
               OP_SUB: begin
                  regs_n[0] = regs_ff[0] - rv;
                  pp_n = pp_ff + 32'd2;
               end
               OP_MUL: begin
                  regs_n[0] = product_ff;
                  pp_n = pp_ff + 32'd2;
               end
               OP_DIV: begin
                  if (rv == 32'd0) status_n = ST_DIV_ZERO;
                  else regs_n[0] = neg_ff ? (32'd0 - quot_ff) : quot_ff;
                  pp_n = pp_ff + 32'd2;
               end
               OP_INC: begin
                  regs_n[rsel] = rv + 32'd1;
                  pp_n = pp_ff + 32'd2;
               end
               OP_DEC: begin
                  regs_n[rsel] = rv - 32'd1;
                  pp_n = pp_ff + 32'd2;
               end
               OP_LOOP: pp_n = (regs_ff[2] != 32'd0) ? item_ff.operand_one : pp_ff + 32'd2;
               OP_MOVR: begin
                  regs_n[rsel] = item_ff.operand_two;
                  pp_n = pp_ff + 32'd3;
               end
               OP_LOAD, OP_STORE: begin
                  pp_n = pp_ff + 32'd2;
                  if (!slot_ok) begin
                     status_n = ST_STACK;
                  end else begin
                     if (op == OP_LOAD) regs_n[rsel] = mem_rd_ff;
                     else mem_we = 1'b1;
                     pp_n = pp_ff + 32'd3;
                  end
               end
               OP_IN: begin
                  pp_n = pp_ff + 32'd1;
                  if (item_ff.console_condition == COND_EOF) begin
                     regs_n[2] = 32'd0;
                     regs_n[rsel] = 32'hFFFF_FFFF;
                     pp_n = pp_ff + 32'd2;
                  end else if (item_ff.console_condition == COND_VALUE) begin
                     regs_n[rsel] = item_ff.console_value;
                     pp_n = pp_ff + 32'd2;
                  end else begin
                     status_n = ST_IO;
                  end
               end
               OP_GET: begin
                  if (item_ff.console_condition == COND_EOF) begin
                     regs_n[2] = 32'd0;
                     regs_n[rsel] = 32'hFFFF_FFFF;
                  end else begin
                     regs_n[rsel] = item_ff.console_value & CharMaxCode;
                  end
                  pp_n = pp_ff + 32'd2;
               end
               OP_OUT: begin
                  pkind_n = PRINT_NUMBER;
                  pval_n = rv;
                  pp_n = pp_ff + 32'd2;
               end
               OP_PUT: begin
                  pp_n = pp_ff + 32'd1;
                  if (rv <= CharMaxCode) begin
                     pkind_n = PRINT_CHAR;
                     pval_n = rv;
                     pp_n = pp_ff + 32'd2;
                  end else begin
                     status_n = ST_BAD_OPERAND;
                  end
               end
               OP_SWAP: begin
                  tmp = regs_ff[rsel];
                  regs_n[rsel] = regs_ff[r2sel];
                  regs_n[r2sel] = tmp;
                  pp_n = pp_ff + 32'd3;
               end
               OP_PUSH: begin
                  pp_n = pp_ff + 32'd1;
                  if (push_full) begin
                     status_n = ST_STACK;
                  end else begin
                     mem_we = 1'b1;
                     mem_wa = AW'(depth_ff);
                     depth_n = depth_ff + 9'd1;
                     pp_n = pp_ff + 32'd2;
                  end
               end
               OP_POP: begin
                  pp_n = pp_ff + 32'd1;
                  if (depth_ff == 9'd0) begin
                     status_n = ST_STACK;
                  end else begin
                     depth_n = depth_ff - 9'd1;
                     regs_n[rsel] = mem_rd_ff;
                     pp_n = pp_ff + 32'd2;
                  end
               end
               default: status_n = ST_BAD_INSTR;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff   <= '{default: 32'd0};
         pp_ff     <= 32'd0;
         status_ff <= ST_OK;
         depth_ff  <= 9'd0;
      end else if (cmd.commit) begin
         regs_ff   <= regs_n;
         pp_ff     <= pp_n;
         status_ff <= status_n;
         depth_ff  <= depth_n;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
      if (cmd.decode) begin
         mem_rd_ff  <= stack_mem[rd_addr];
         product_ff <= regs_ff[0] * rv;
         rem_ff     <= 32'd0;
         quot_ff    <= mag_a;
         divisor_ff <= mag_b;
         neg_ff     <= regs_ff[0][31] ^ rv[31];
      end
      // restoring divide, one quotient bit per cycle
      if (cmd.div_step) begin
         rem_ff  <= rem_ge ? 32'(rem_shift - {1'b0, divisor_ff}) : rem_shift[31:0];
         quot_ff <= {quot_ff[30:0], rem_ge};
      end
      if (cmd.commit && mem_we) stack_mem[mem_wa] <= rv;
      if (cmd.commit) begin
         rsp_ff.status       <= status_n;
         rsp_ff.next_address <= pp_n;
         rsp_ff.print_kind   <= pkind_n;
         rsp_ff.print_value  <= pval_n;
         rsp_ff.stack_count  <= depth_n;
         rsp_ff.reg_a_value  <= regs_n[0];
         rsp_ff.reg_b_value  <= regs_n[1];
         rsp_ff.reg_c_value  <= regs_n[2];
         rsp_ff.reg_d_value  <= regs_n[3];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> rtl/core/frsc_control.sv
module frsc_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  frsc_pkg::dp_sts_type  sts,
   output frsc_pkg::ctl_cmd_type cmd
);
   import frsc_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_COMMIT
   } state_type;

   state_type state_ff;
   logic [4:0] div_cnt_ff;
   logic       rsp_valid_ff;
   logic       slot_free;

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready   = state_ff == S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture  = req_valid && (state_ff == S_IDLE);
   assign cmd.decode   = state_ff == S_DECODE;
   assign cmd.div_step = state_ff == S_DIV;
   assign cmd.commit   = (state_ff == S_COMMIT) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_DECODE;
            S_DECODE: begin
               div_cnt_ff <= 5'd0;
               state_ff   <= sts.need_div ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'd31) state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (slot_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

>>> rtl/core/four_register_stack_cpu_step_core.sv
// Executes one instruction of the four-register stack machine per request
// transaction and returns one response with status, next fetch address, console
// output, stack count and registers A..D. An instruction goes through the
// cycle in which the request is accepted and captured, decode with the stack
// memory read and multiply, and commit, which loads the response register. The
// next request is accepted in the cycle after commit. A divide with a nonzero
// divisor adds the one-bit-per-cycle divider steps between decode and commit.
// The response register lets a new request be accepted while the previous
// response waits; commit stalls only while that register is still full.
module four_register_stack_cpu_step_core #(
   parameter int unsigned STACK_DEPTH = frsc_pkg::DefaultStackDepth
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  frsc_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output frsc_pkg::rsp_type             rsp_data,
   input  logic                          csr_wr_en,
   input  logic                          csr_index,
   input  logic [frsc_pkg::CsrWidth-1:0] csr_wdata
);
   import frsc_pkg::*;

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   frsc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   frsc_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

>>> dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import frsc_pkg::*;

   localparam int unsigned CycleLimit = 2000000;
   localparam int unsigned RandomItems = 1400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic csr_index = CSR_CODE_WORDS;
   logic [CsrWidth-1:0] csr_wdata = '0;

   four_register_stack_cpu_step_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // machine state as the block should hold it
   logic [31:0] gpr [4];
   logic [31:0] ip;
   status_type mstate;
   int unsigned sdepth;
   logic [31:0] sstore [256];
   int unsigned cfg_code_words;
   int unsigned cfg_stack_cap;

   rsp_type step_results_q [$];
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   bit quiet = 1'b0;
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side stalls in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (step_results_q.size() == 0) begin
            error_count++;
            $display("%0t unexpected response transaction %h", $time, rsp_data);
         end else begin
            want = step_results_q.pop_front();
            report("status", want.status, rsp_data.status);
            report("next_address", want.next_address, rsp_data.next_address);
            report("print_kind", want.print_kind, rsp_data.print_kind);
            report("print_value", want.print_value, rsp_data.print_value);
            report("stack_count", want.stack_count, rsp_data.stack_count);
            report("reg_a", want.reg_a_value, rsp_data.reg_a_value);
            report("reg_b", want.reg_b_value, rsp_data.reg_b_value);
            report("reg_c", want.reg_c_value, rsp_data.reg_c_value);
            report("reg_d", want.reg_d_value, rsp_data.reg_d_value);
         end
      end
   end

   function automatic int reg_select(input logic [31:0] word);
      if (word > 3) begin
         mstate = ST_BAD_OPERAND;
         return 0;
      end
      return int'(word);
   endfunction

   task automatic execute_step(input req_type it, output rsp_type res);
      logic [31:0] npc, v;
      logic [1:0] pkind;
      logic [31:0] pval;
      int r, r2;
      longint k;
      int unsigned lim, idx;
      pkind = PRINT_NONE;
      pval = '0;
      if (mstate == ST_OK) begin
         if (int'(ip) < 0 || int'(ip) >= int'(cfg_code_words)) begin
            mstate = ST_BAD_ADDR;
         end else begin
            npc = ip;
            lim = (cfg_stack_cap < 256) ? cfg_stack_cap : 256;
            case (it.opcode)
               OP_NOP: npc += 1;
               OP_HALT: mstate = ST_HALT;
               OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                  r = reg_select(it.operand_one);
                  v = gpr[r];
                  if (it.opcode == OP_ADD) gpr[0] += v;
                  else if (it.opcode == OP_SUB) gpr[0] -= v;
                  else if (it.opcode == OP_MUL) gpr[0] *= v;
                  else if (v == 0) mstate = ST_DIV_ZERO;
                  else if (gpr[0] == 32'h8000_0000 && v == 32'hFFFF_FFFF) gpr[0] = gpr[0];
                  else gpr[0] = $signed(gpr[0]) / $signed(v);
                  npc += 2;
               end
               OP_INC, OP_DEC: begin
                  r = reg_select(it.operand_one);
                  gpr[r] += (it.opcode == OP_INC) ? 32'd1 : 32'hFFFF_FFFF;
                  npc += 2;
               end
               OP_LOOP: npc = (gpr[2] != 0) ? it.operand_one : npc + 2;
               OP_MOVR: begin
                  r = reg_select(it.operand_one);
                  gpr[r] = it.operand_two;
                  npc += 3;
               end
               OP_LOAD, OP_STORE: begin
                  r = reg_select(it.operand_one);
                  npc += 2;
                  // offset sum is exact, no 32-bit wrap
                  k = longint'($signed(gpr[3])) + longint'($signed(it.operand_two));
                  if (sdepth == 0 || k < 0 || k > longint'(sdepth) - 1) begin
                     mstate = ST_STACK;
                  end else begin
                     idx = sdepth - 1 - int'(k);
                     if (it.opcode == OP_LOAD) gpr[r] = sstore[idx];
                     else sstore[idx] = gpr[r];
                     npc += 1;
                  end
               end
               OP_IN: begin
                  r = reg_select(it.operand_one);
                  npc += 1;
                  if (it.console_condition == COND_EOF) begin
                     gpr[2] = '0;
                     gpr[r] = 32'hFFFF_FFFF;
                     npc += 1;
                  end else if (it.console_condition == COND_VALUE) begin
                     gpr[r] = it.console_value;
                     npc += 1;
                  end else begin
                     mstate = ST_IO;
                  end
               end
               OP_GET: begin
                  r = reg_select(it.operand_one);
                  if (it.console_condition == COND_EOF) begin
                     gpr[2] = '0;
                     gpr[r] = 32'hFFFF_FFFF;
                  end else begin
                     gpr[r] = it.console_value & CharMaxCode;
                  end
                  npc += 2;
               end
               OP_OUT: begin
                  r = reg_select(it.operand_one);
                  pkind = PRINT_NUMBER;
                  pval = gpr[r];
                  npc += 2;
               end
               OP_PUT: begin
                  r = reg_select(it.operand_one);
                  v = gpr[r];
                  npc += 1;
                  if (v <= CharMaxCode) begin
                     pkind = PRINT_CHAR;
                     pval = v;
                     npc += 1;
                  end else begin
                     mstate = ST_BAD_OPERAND;
                  end
               end
               OP_SWAP: begin
                  r = reg_select(it.operand_one);
                  r2 = reg_select(it.operand_two);
                  v = gpr[r];
                  gpr[r] = gpr[r2];
                  gpr[r2] = v;
                  npc += 3;
               end
               OP_PUSH: begin
                  r = reg_select(it.operand_one);
                  npc += 1;
                  if (sdepth >= lim) begin
                     mstate = ST_STACK;
                  end else begin
                     sstore[sdepth] = gpr[r];
                     sdepth++;
                     npc += 1;
                  end
               end
               OP_POP: begin
                  r = reg_select(it.operand_one);
                  npc += 1;
                  if (sdepth == 0) begin
                     mstate = ST_STACK;
                  end else begin
                     sdepth--;
                     gpr[r] = sstore[sdepth];
                     npc += 1;
                  end
               end
               default: mstate = ST_BAD_INSTR;
            endcase
            ip = npc;
         end
      end
      res.status = mstate;
      res.next_address = ip;
      res.print_kind = pkind;
      res.print_value = pval;
      res.stack_count = sdepth[8:0];
      res.reg_a_value = gpr[0];
      res.reg_b_value = gpr[1];
      res.reg_c_value = gpr[2];
      res.reg_d_value = gpr[3];
   endtask

   function automatic req_type make_item(input logic [31:0] op, input logic [31:0] o1,
                                         input logic [31:0] o2,
                                         input logic [31:0] cv = $urandom,
                                         input logic [1:0] cd = COND_VALUE);
      req_type it;
      it.opcode = op;
      it.operand_one = o1;
      it.operand_two = o2;
      it.console_value = cv;
      it.console_condition = cd;
      return it;
   endfunction

   task automatic send_item(input req_type it);
      rsp_type res;
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      execute_step(it, res);
      step_results_q.push_back(res);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (step_results_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CsrWidth-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CODE_WORDS) cfg_code_words = value & 32'h1F_FFFF;
      else cfg_stack_cap = value & 32'h1FF;
   endtask

   // jump the program back to a given address so the code size can shrink
   task automatic rewind_program(input logic [31:0] target);
      if (gpr[2] == 0) send_item(make_item(OP_MOVR, 2, 1));
      send_item(make_item(OP_LOOP, target, $urandom));
   endtask

   task automatic set_code_words(input int unsigned value);
      rewind_program(0);
      wait_drained();
      csr_write(CSR_CODE_WORDS, value);
   endtask

   // builds an instruction that keeps the machine out of every error state
   task automatic make_legal(output req_type it, input int unsigned push_bias);
      int r;
      int unsigned lim, k;
      longint off;
      logic [31:0] op;
      lim = (cfg_stack_cap < 256) ? cfg_stack_cap : 256;
      it = make_item($urandom_range(0, 18), $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom, 2'($urandom_range(0, 3)));
      r = int'(it.operand_one);
      op = it.opcode;
      if (int'(ip) > int'(cfg_code_words) - 12) begin
         if (gpr[2] == 0) it = make_item(OP_MOVR, 2, $urandom_range(1, 32'hFFFF_FFFF));
         else it = make_item(OP_LOOP, $urandom_range(0, cfg_code_words - 12), $urandom);
         return;
      end
      if ($urandom_range(0, 99) < push_bias) op = OP_PUSH;
      case (op)
         OP_NOP: it = make_item(OP_NOP, $urandom, $urandom, $urandom, 2'($urandom));
         OP_HALT: it.opcode = OP_GET;
         OP_DIV: if (gpr[r] == 0) it.opcode = OP_INC;
         OP_LOOP: it.operand_one = (gpr[2] != 0) ? $urandom_range(0, cfg_code_words - 12)
                                                 : $urandom;
         OP_MOVR: begin
            it.operand_two = $urandom;
            if ($urandom_range(0, 3) == 0) it.operand_two = $urandom_range(0, 8);
         end
         OP_LOAD, OP_STORE: begin
            if (sdepth == 0) begin
               it.opcode = (lim > 0) ? OP_PUSH : OP_NOP;
            end else begin
               k = $urandom_range(0, sdepth - 1);
               off = longint'(k) - longint'($signed(gpr[3]));
               if (off > 32'sh7FFF_FFFF || off < -64'sd2147483648)
                  it = make_item(OP_MOVR, 3, $urandom_range(0, 3));
               else
                  it.operand_two = off[31:0];
            end
         end
         OP_IN: it.console_condition = $urandom_range(0, 1) ? COND_EOF : COND_VALUE;
         OP_PUT: if (gpr[r] > CharMaxCode) it.opcode = OP_GET;
         OP_PUSH: begin
            if (sdepth < lim) it.opcode = OP_PUSH;
            else it.opcode = (sdepth > 0) ? OP_POP : OP_NOP;
         end
         OP_POP: if (sdepth == 0) it.opcode = (lim > 0) ? OP_PUSH : OP_NOP;
         default: it.opcode = op;
      endcase
   endtask

   task automatic test_directed();
      send_item(make_item(OP_MOVR, 0, 32'h7FFF_FFFF));
      send_item(make_item(OP_INC, 0, 0));
      send_item(make_item(OP_MOVR, 1, 32'hFFFF_FFFF));
      send_item(make_item(OP_DIV, 1, 0));
      send_item(make_item(OP_MUL, 1, 0));
      send_item(make_item(OP_SUB, 1, 0));
      send_item(make_item(OP_ADD, 1, 0));
      send_item(make_item(OP_DEC, 2, 0));
      send_item(make_item(OP_PUSH, 0, 0));
      send_item(make_item(OP_PUSH, 1, 0));
      send_item(make_item(OP_STORE, 2, 1));
      send_item(make_item(OP_LOAD, 3, 0));
      send_item(make_item(OP_POP, 2, 0));
      send_item(make_item(OP_OUT, 0, 0));
      send_item(make_item(OP_MOVR, 0, 65));
      send_item(make_item(OP_PUT, 0, 0));
      send_item(make_item(OP_SWAP, 0, 1));
      send_item(make_item(OP_IN, 0, 0, 32'h8000_0000, COND_VALUE));
      send_item(make_item(OP_IN, 1, 0, $urandom, COND_EOF));
      send_item(make_item(OP_GET, 3, 0, 32'hFFFF_FF34, COND_MALFORMED));
      send_item(make_item(OP_GET, 0, 0, 32'h0000_01FF, COND_OTHER));
      send_item(make_item(OP_LOOP, 0, 0));
      send_item(make_item(OP_INC, 2, 0));
      send_item(make_item(OP_LOOP, 0, 0));
      send_item(make_item(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, COND_OTHER));
   endtask

   task automatic test_config_extremes();
      req_type it;
      set_code_words(1);
      repeat (8) send_item(make_item(OP_LOOP, 0, $urandom));
      wait_drained();
      csr_write(CSR_CODE_WORDS, 1048576);
      csr_write(CSR_STACK_CAPACITY, 0);
      repeat (40) begin
         make_legal(it, 30);
         send_item(it);
      end
      wait_drained();
      csr_write(CSR_STACK_CAPACITY, 256);
   endtask

   task automatic test_random_programs();
      req_type it;
      int unsigned sent, bias, cw;
      sent = 0;
      while (sent < RandomItems) begin
         cw = ($urandom_range(0, 4) == 0) ? 1048576 : $urandom_range(16, 2048);
         set_code_words(cw);
         wait_drained();
         case ($urandom_range(0, 3))
            0: csr_write(CSR_STACK_CAPACITY, 256);
            1: csr_write(CSR_STACK_CAPACITY, 0);
            default: csr_write(CSR_STACK_CAPACITY, $urandom_range(1, 255));
         endcase
         bias = $urandom_range(0, 40);
         repeat ($urandom_range(100, 300)) begin
            make_legal(it, bias);
            send_item(it);
            sent++;
            if (sent == RandomItems / 2) wait_drained();
         end
      end
   endtask

   // one error or a halt ends normal execution; every later transaction must see frozen state
   task automatic test_sticky_error();
      int unsigned lim;
      quiet = 1'b1;
      case ($urandom_range(0, 9))
         0: send_item(make_item(OP_HALT, $urandom, $urandom));
         1: send_item(make_item($urandom_range(19, 32'hFFFF_FFFF), $urandom, $urandom));
         2: send_item(make_item($urandom_range(2, 18), $urandom_range(4, 32'hFFFF_FFFF),
                                $urandom_range(0, 3)));
         3: begin
            send_item(make_item(OP_MOVR, 1, 0));
            send_item(make_item(OP_DIV, 1, 0));
         end
         4: begin
            send_item(make_item(OP_MOVR, 3, 32'h7FFF_FFFF));
            send_item(make_item(OP_LOAD, 0, 32'h7FFF_FFFF));
         end
         5: send_item(make_item(OP_IN, 0, 0, $urandom,
                                $urandom_range(0, 1) ? COND_MALFORMED : COND_OTHER));
         6: begin
            send_item(make_item(OP_MOVR, 0, $urandom_range(256, 32'hFFFF_FFFF)));
            send_item(make_item(OP_PUT, 0, 0));
         end
         7: begin
            lim = sdepth;
            wait_drained();
            csr_write(CSR_STACK_CAPACITY, lim);
            send_item(make_item(OP_PUSH, 1, 0));
         end
         8: begin
            while (sdepth > 0) send_item(make_item(OP_POP, $urandom_range(0, 3), 0));
            send_item(make_item(OP_POP, 0, 0));
         end
         default: begin
            rewind_program(10);
            wait_drained();
            csr_write(CSR_CODE_WORDS, 5);
            send_item(make_item(OP_NOP, 0, 0));
         end
      endcase
      repeat (30) send_item(make_item($urandom, $urandom, $urandom, $urandom, 2'($urandom)));
   endtask

   initial begin
      for (int i = 0; i < 4; i++) gpr[i] = '0;
      for (int i = 0; i < 256; i++) sstore[i] = '0;
      ip = '0;
      mstate = ST_OK;
      sdepth = 0;
      cfg_code_words = CodeWordsReset;
      cfg_stack_cap = StackCapReset;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random_programs();
      test_sticky_error();
      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
